// File: rtl/linear_probe_hash_table_assert.svh
// assertion macros used by rtl/linear_probe_hash_table.sv
// all macros sample on clk and are disabled while rst_n is low
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// same-cycle implication
`define LPHT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition that must never be seen
`define LPHT_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// File: rtl/lpht_pkg.sv
package lpht_pkg;

  // table geometry
  localparam int TABLE_SIZE = 16;
  localparam int IDX_W      = (TABLE_SIZE > 2) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

  // field widths
  localparam int FUNC_W   = 1;
  localparam int KEY_W    = 31;
  localparam int NAME_W   = 32;
  localparam int VALUE_W  = 34;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  // home slot reduction, one chunk of key bits per cycle
  localparam int CHUNK_W    = 8;
  localparam int KEY_CHUNKS = (KEY_W + CHUNK_W - 1) / CHUNK_W;
  localparam int KEY_PAD_W  = KEY_CHUNKS * CHUNK_W;
  localparam int HCNT_W     = (KEY_CHUNKS > 2) ? $clog2(KEY_CHUNKS) : 1;

  localparam logic [IDX_W:0]    TS_MOD    = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0]  TS_CNT    = CNT_W'(TABLE_SIZE);
  localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(TABLE_SIZE - 1);
  localparam logic [HCNT_W-1:0] LAST_HCNT = HCNT_W'(KEY_CHUNKS - 1);

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_STORED   = 2'd0,
    STAT_FOUND    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [NAME_W-1:0]  name;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

endpackage

// File: rtl/lpht_mem.sv
module lpht_mem import lpht_pkg::*; (
  input  logic             clk,
  input  wr_req_t          wr,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [TABLE_SIZE];
  entry_t rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/linear_probe_hash_table.sv
// channel  direction  ports
// in_      input      in_valid, in_ready, in_func, in_key, in_name_tag, in_phone_value
// out_     output     out_valid, out_ready, out_status, out_slot, out_found_key,
//                     out_found_name, out_found_value
//
// one transaction at a time: accept, home slot reduction of the key
// (8 key bits per cycle), then 1 to 16 slot probes at one entry read per cycle,
// each slot checked once its read data returns, then the result is handed over.
// the entry memory read port sets the probe rate.
// rst_n clears the slot valid map, so the table starts empty.
// a result waiting on out_ready does not block the next transaction until its
// own result is due.
module linear_probe_hash_table import lpht_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [NAME_W-1:0]  in_name_tag,
  input  logic [VALUE_W-1:0] in_phone_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [KEY_W-1:0]   out_found_key,
  output logic [NAME_W-1:0]  out_found_name,
  output logic [VALUE_W-1:0] out_found_value
);

  // control state
  state_t                 state_r, state_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [TABLE_SIZE-1:0]  slot_used_r, slot_used_nxt;
  logic                   chk_vld_r, chk_vld_nxt;

  // request and probe datapath
  logic [FUNC_W-1:0]      req_func_r, req_func_nxt;
  entry_t                 req_entry_r, req_entry_nxt;
  logic [KEY_PAD_W-1:0]   key_sh_r, key_sh_nxt;
  logic [IDX_W-1:0]       rem_r, rem_nxt;
  logic [HCNT_W-1:0]      hcnt_r, hcnt_nxt;
  logic [IDX_W-1:0]       rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]       iss_cnt_r, iss_cnt_nxt;
  logic [IDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic                   chk_last_r, chk_last_nxt;

  // pending result and output register
  status_t                res_status_r, res_status_nxt;
  logic [IDX_W-1:0]       res_idx_r, res_idx_nxt;
  entry_t                 res_entry_r, res_entry_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  entry_t                 out_entry_r, out_entry_nxt;

  logic [IDX_W-1:0]       rem_step;
  entry_t                 rd_data;
  wr_req_t                wr;

  // entry memory
  lpht_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  // home slot reduction: one chunk of key bits, msb first
  always_comb begin
    logic [IDX_W:0]   t;
    logic [IDX_W-1:0] r;
    r = rem_r;
    t = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      t = {r, key_sh_r[KEY_PAD_W-1-i]};
      if (t >= TS_MOD) begin
        t = t - TS_MOD;
      end
      r = t[IDX_W-1:0];
    end
    rem_step = r;
  end

  // sequencer: next state, probe control and result capture
  always_comb begin
    logic used;
    logic hit_free;
    logic hit_match;
    logic give_up;
    logic out_free;

    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    slot_used_nxt  = slot_used_r;
    chk_vld_nxt    = chk_vld_r;
    req_func_nxt   = req_func_r;
    req_entry_nxt  = req_entry_r;
    key_sh_nxt     = key_sh_r;
    rem_nxt        = rem_r;
    hcnt_nxt       = hcnt_r;
    rd_idx_nxt     = rd_idx_r;
    iss_cnt_nxt    = iss_cnt_r;
    chk_idx_nxt    = chk_idx_r;
    chk_last_nxt   = chk_last_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_entry_nxt  = res_entry_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_entry_nxt  = out_entry_r;
    wr             = '0;
    in_ready       = 1'b0;

    used      = slot_used_r[chk_idx_r];
    hit_free  = chk_vld_r && !used;
    hit_match = chk_vld_r && used && (req_func_r == FUNC_SEARCH) &&
                (rd_data.key == req_entry_r.key);
    give_up   = chk_vld_r && chk_last_r && !hit_free && !hit_match;
    out_free  = !out_valid_r || out_ready;

    // result handed over
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_func_nxt        = in_func;
          req_entry_nxt.key   = in_key;
          req_entry_nxt.name  = in_name_tag;
          req_entry_nxt.value = in_phone_value;
          key_sh_nxt          = KEY_PAD_W'(in_key);
          rem_nxt             = '0;
          hcnt_nxt            = '0;
          state_nxt           = ST_HASH;
        end
      end

      ST_HASH: begin
        key_sh_nxt = key_sh_r << CHUNK_W;
        rem_nxt    = rem_step;
        hcnt_nxt   = hcnt_r + 1'b1;
        if (hcnt_r == LAST_HCNT) begin
          rd_idx_nxt  = rem_step;
          iss_cnt_nxt = '0;
          chk_vld_nxt = 1'b0;
          state_nxt   = ST_PROBE;
        end
      end

      ST_PROBE: begin
        if (hit_free || hit_match || give_up) begin
          chk_vld_nxt = 1'b0;
          state_nxt   = ST_FINISH;
          if (hit_match) begin
            res_status_nxt = STAT_FOUND;
            res_idx_nxt    = chk_idx_r;
            res_entry_nxt  = rd_data;
          end else if (hit_free && (req_func_r == FUNC_INSERT)) begin
            res_status_nxt = STAT_STORED;
            res_idx_nxt    = chk_idx_r;
            res_entry_nxt  = req_entry_r;
          end else begin
            res_status_nxt = (req_func_r == FUNC_INSERT) ? STAT_FULL : STAT_NOTFOUND;
            res_idx_nxt    = '0;
            res_entry_nxt  = '0;
          end
        end else if (iss_cnt_r < TS_CNT) begin
          // issue the next slot read, check it in the following cycle
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = rd_idx_r;
          chk_last_nxt = (iss_cnt_r == LAST_CNT);
          iss_cnt_nxt  = iss_cnt_r + 1'b1;
          rd_idx_nxt   = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = SLOT_W'(res_idx_r);
          out_entry_nxt  = res_entry_r;
          if (res_status_r == STAT_STORED) begin
            slot_used_nxt[res_idx_r] = 1'b1;
            wr.en   = 1'b1;
            wr.addr = res_idx_r;
            wr.data = req_entry_r;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      slot_used_r <= '0;
      chk_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      slot_used_r <= slot_used_nxt;
      chk_vld_r   <= chk_vld_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    req_func_r   <= req_func_nxt;
    req_entry_r  <= req_entry_nxt;
    key_sh_r     <= key_sh_nxt;
    rem_r        <= rem_nxt;
    hcnt_r       <= hcnt_nxt;
    rd_idx_r     <= rd_idx_nxt;
    iss_cnt_r    <= iss_cnt_nxt;
    chk_idx_r    <= chk_idx_nxt;
    chk_last_r   <= chk_last_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_entry_r  <= res_entry_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_entry_r  <= out_entry_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_found_key   = out_entry_r.key;
  assign out_found_name  = out_entry_r.name;
  assign out_found_value = out_entry_r.value;

  `include "linear_probe_hash_table_assert.svh"

  // probe issue never runs past one full sweep
  `LPHT_ASSERT_NEVER(a_iss_bound, iss_cnt_r > TS_CNT && state_r == ST_PROBE, "probe count past table size")

  // a pending slot check only exists while probing
  `LPHT_ASSERT_IMPL(a_chk_in_probe, chk_vld_r, state_r == ST_PROBE, "slot check outside probe")

  // a stored result leaves its slot marked used
  `LPHT_ASSERT_NEXT(a_store_marks, state_r == ST_FINISH && (!out_valid_r || out_ready) && res_status_r == STAT_STORED, slot_used_r[$past(res_idx_r)], "stored slot not marked used")

  // miss and full results carry no entry
  `LPHT_ASSERT_IMPL(a_miss_zero, out_valid_r && (out_status_r == STAT_NOTFOUND || out_status_r == STAT_FULL), out_slot_r == '0 && out_entry_r == '0, "miss result carries entry fields")

endmodule
